// ===== rtl/core/envc_pkg.sv =====
// ----------------------------------------------------------------------------
// envc_pkg
// Shared constants and types of the envelope compressor: defaults, register
// indexes and fixed field widths.
// ----------------------------------------------------------------------------
package envc_pkg;

	localparam int SAMPLE_WIDTH_DEF    = 16;
	localparam int COEFF_FRAC_BITS_DEF = 16;

	// Level is the rectified sample shifted up by this many bits.
	localparam int ENV_EXTRA = 8;

	localparam int REG_WIDTH  = 16;
	localparam int IDX_WIDTH  = 3;
	localparam int GAIN_WIDTH = 17;
	localparam int SLOPE_FRAC = 16;

	localparam logic [GAIN_WIDTH-1:0] GAIN_ONE = 17'h10000;
	localparam logic [REG_WIDTH-1:0]  THR_MAX  = 16'h8000;

	localparam logic                 ENABLE_RST    = 1'b1;
	localparam logic [REG_WIDTH-1:0] THRESHOLD_RST = 16'd22938;
	localparam logic [REG_WIDTH-1:0] ATTACK_RST    = 16'd65387;
	localparam logic [REG_WIDTH-1:0] RELEASE_RST   = 16'd65521;
	localparam logic [REG_WIDTH-1:0] SLOPE_RST     = 16'd49152;

	typedef enum logic [IDX_WIDTH-1:0] {
		REG_ENABLE        = 3'd0,
		REG_THRESHOLD     = 3'd1,
		REG_ATTACK_COEFF  = 3'd2,
		REG_RELEASE_COEFF = 3'd3,
		REG_SLOPE         = 3'd4
	} reg_index_t;

endpackage

// ===== rtl/core/envelope_compressor.sv =====
// ----------------------------------------------------------------------------
// envelope_compressor
// Feed-forward dynamic range compressor built around one shared multiplier
// and a radix-2 serial divider.
// ----------------------------------------------------------------------------
// One item is accepted at a time. With compression enabled an item whose
// smoothed envelope stays at or below the threshold skips the slope product
// and the divider; one that crosses the threshold also runs through the 16
// iterations of the serial gain divider. With enable at 0 an item goes
// straight to the output stage. Every product (envelope smoothing, overshoot times
// slope, sample times gain) goes through the same registered multiplier in
// successive steps. The finished item sits in an output register, so the next
// item is taken while the previous result still waits for m_tready.
// ----------------------------------------------------------------------------
module envelope_compressor import envc_pkg::*; #(
	parameter int SAMPLE_WIDTH    = SAMPLE_WIDTH_DEF,
	parameter int COEFF_FRAC_BITS = COEFF_FRAC_BITS_DEF
) (
	input  logic                                      clk,
	input  logic                                      arst_n,
	// Slave stream: sample_in
	input  logic                                      s_tvalid,
	output logic                                      s_tready,
	input  logic [((SAMPLE_WIDTH+7)/8)*8-1:0]         s_tdata,	// sample_in
	// Master stream: sample_out, gain_applied
	output logic                                      m_tvalid,
	input  logic                                      m_tready,
	output logic [((SAMPLE_WIDTH+GAIN_WIDTH+7)/8)*8-1:0] m_tdata,	// sample_out, gain_applied
	// Configuration write channel
	input  logic                                      cfg_valid,
	output logic                                      cfg_ready,
	input  logic [IDX_WIDTH-1:0]                      cfg_index,
	input  logic [REG_WIDTH-1:0]                      cfg_data
);

	localparam int SW   = SAMPLE_WIDTH;
	localparam int F    = COEFF_FRAC_BITS;
	localparam int EW   = SW + ENV_EXTRA;
	localparam int OW   = ((SW + GAIN_WIDTH + 7) / 8) * 8;
	localparam int MAW  = EW + 1;
	localparam int MBW  = ((F + 1 > GAIN_WIDTH) ? F + 1 : GAIN_WIDTH) + 1;
	localparam int PW   = MAW + MBW;
	localparam int ACCW = EW + F + 1;
	localparam int RNDW = SW + GAIN_WIDTH + 1;
	localparam int CMAX = (1 << F) - 1;
	localparam int DCW  = $clog2(SLOPE_FRAC);

	localparam logic [ACCW-1:0] ACC_HALF = ACCW'(1) << (F - 1);
	localparam logic [F:0]      COEFF_ONE = (F + 1)'(1) << F;
	localparam logic [EW-1:0]   ENV_FULL = EW'(1) << (EW - 1);
	localparam logic [RNDW-1:0] RND_HALF = RNDW'(1) << (SLOPE_FRAC - 1);

	typedef enum logic [3:0] {
		ST_IDLE,
		ST_MUL_C,
		ST_MUL_L,
		ST_ENV,
		ST_CMP,
		ST_MUL_S,
		ST_DIV_LOAD,
		ST_DIV,
		ST_MUL_G,
		ST_ROUND,
		ST_DONE
	} state_t;

	state_t state_q;

	// Configuration registers
	logic                 enable_q;
	logic [REG_WIDTH-1:0] threshold_q;
	logic [REG_WIDTH-1:0] attack_q;
	logic [REG_WIDTH-1:0] release_q;
	logic [REG_WIDTH-1:0] slope_q;

	// Datapath
	logic [EW-1:0]            env_q;
	logic signed [SW-1:0]     x_q;
	logic [EW-1:0]            lvl_q;
	logic [F-1:0]             c_q;
	logic [ACCW-1:0]          acc_q;
	logic signed [PW-1:0]     prod_q;
	logic [EW-1:0]            rem_q;
	logic [SLOPE_FRAC-1:0]    num_q;
	logic [DCW-1:0]           cnt_q;
	logic [GAIN_WIDTH-1:0]    gain_q;
	logic [SW-1:0]            res_sample_q;
	logic [GAIN_WIDTH-1:0]    res_gain_q;
	logic [SW-1:0]            out_sample_q;
	logic [GAIN_WIDTH-1:0]    out_gain_q;
	logic                     m_tvalid_q;

	logic [SW-1:0]            sample_raw;
	logic [SW-1:0]            mag;
	logic [EW-1:0]            lvl;
	logic [REG_WIDTH-1:0]     coeff_sel;
	logic [F-1:0]             coeff_clamped;
	logic [REG_WIDTH-1:0]     thr_clamped;
	logic [EW-1:0]            thr;
	logic signed [MAW-1:0]    mul_a;
	logic signed [MBW-1:0]    mul_b;
	logic [ACCW-1:0]          env_sum;
	logic [EW:0]              rem_shift;
	logic                     rem_ge;
	logic [EW:0]              rem_diff;
	logic [RNDW-1:0]          rnd;
	logic                     in_acc;
	logic                     out_free;

	assign cfg_ready = 1'b1;
	assign s_tready  = (state_q == ST_IDLE);
	assign in_acc    = s_tvalid && s_tready;
	assign out_free  = !m_tvalid_q || m_tready;
	assign m_tvalid  = m_tvalid_q;
	assign m_tdata   = OW'({out_gain_q, out_sample_q});

	// Rectify the incoming sample; the most negative value maps to 2^(SW-1).
	always_comb begin
		sample_raw = s_tdata[SW-1:0];
		mag        = sample_raw[SW-1] ? (~sample_raw + 1'b1) : sample_raw;
		lvl        = {mag, {ENV_EXTRA{1'b0}}};
		coeff_sel  = (lvl > env_q) ? attack_q : release_q;
		if (32'(coeff_sel) > CMAX) begin
			coeff_clamped = F'(CMAX);
		end else begin
			coeff_clamped = F'(coeff_sel);
		end
		thr_clamped = (threshold_q > THR_MAX) ? THR_MAX : threshold_q;
		thr         = EW'(thr_clamped) << (SW - 8);
	end

	// Operand selection for the shared multiplier.
	always_comb begin
		unique case (state_q)
			ST_MUL_C: begin
				mul_a = MAW'(env_q);
				mul_b = MBW'(c_q);
			end
			ST_MUL_L: begin
				mul_a = MAW'(lvl_q);
				mul_b = MBW'(COEFF_ONE - {1'b0, c_q});
			end
			ST_MUL_S: begin
				mul_a = MAW'(env_q - thr);
				mul_b = MBW'(slope_q);
			end
			ST_MUL_G: begin
				mul_a = MAW'(x_q);
				mul_b = MBW'(gain_q);
			end
			default: begin
				mul_a = '0;
				mul_b = '0;
			end
		endcase
	end

	always_comb begin
		env_sum   = acc_q + prod_q[ACCW-1:0] + ACC_HALF;
		rem_shift = {rem_q, num_q[SLOPE_FRAC-1]};
		rem_ge    = rem_shift >= {1'b0, env_q};
		rem_diff  = rem_shift - {1'b0, env_q};
		rnd       = prod_q[RNDW-1:0] + RND_HALF;
	end

	// Configuration writes
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			enable_q    <= ENABLE_RST;
			threshold_q <= THRESHOLD_RST;
			attack_q    <= ATTACK_RST;
			release_q   <= RELEASE_RST;
			slope_q     <= SLOPE_RST;
		end else if (cfg_valid && cfg_ready) begin
			unique case (cfg_index)
				REG_ENABLE:        enable_q    <= cfg_data[0];
				REG_THRESHOLD:     threshold_q <= cfg_data;
				REG_ATTACK_COEFF:  attack_q    <= cfg_data;
				REG_RELEASE_COEFF: release_q   <= cfg_data;
				REG_SLOPE:         slope_q     <= cfg_data;
				default: begin
				end
			endcase
		end
	end

	// Sequencer with its registered datapath
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= ST_IDLE;
			env_q      <= '0;
			m_tvalid_q <= 1'b0;
			cnt_q      <= '0;
		end else begin
			// In ST_DONE the output register is reloaded below instead.
			if (m_tvalid_q && m_tready && state_q != ST_DONE) begin
				m_tvalid_q <= 1'b0;
			end
			unique case (state_q)
				ST_IDLE: begin
					if (in_acc) begin
						x_q   <= sample_raw;
						lvl_q <= lvl;
						c_q   <= coeff_clamped;
						if (enable_q) begin
							state_q <= ST_MUL_C;
						end else begin
							res_sample_q <= sample_raw;
							res_gain_q   <= GAIN_ONE;
							state_q      <= ST_DONE;
						end
					end
				end
				ST_MUL_C: begin
					prod_q  <= mul_a * mul_b;
					state_q <= ST_MUL_L;
				end
				ST_MUL_L: begin
					acc_q   <= prod_q[ACCW-1:0];
					prod_q  <= mul_a * mul_b;
					state_q <= ST_ENV;
				end
				ST_ENV: begin
					env_q   <= env_sum[F +: EW];
					state_q <= ST_CMP;
				end
				ST_CMP: begin
					if (env_q > thr) begin
						state_q <= ST_MUL_S;
					end else begin
						gain_q  <= GAIN_ONE;
						state_q <= ST_MUL_G;
					end
				end
				ST_MUL_S: begin
					prod_q  <= mul_a * mul_b;
					state_q <= ST_DIV_LOAD;
				end
				ST_DIV_LOAD: begin
					// The quotient is below 2^16, so the upper part of the
					// dividend is already smaller than the envelope.
					rem_q   <= prod_q[SLOPE_FRAC +: EW];
					num_q   <= prod_q[SLOPE_FRAC-1:0];
					cnt_q   <= DCW'(SLOPE_FRAC - 1);
					state_q <= ST_DIV;
				end
				ST_DIV: begin
					rem_q <= rem_ge ? rem_diff[EW-1:0] : rem_shift[EW-1:0];
					num_q <= {num_q[SLOPE_FRAC-2:0], rem_ge};
					cnt_q <= cnt_q - 1'b1;
					if (cnt_q == '0) begin
						gain_q  <= GAIN_ONE - {1'b0, num_q[SLOPE_FRAC-2:0], rem_ge};
						state_q <= ST_MUL_G;
					end
				end
				ST_MUL_G: begin
					prod_q  <= mul_a * mul_b;
					state_q <= ST_ROUND;
				end
				ST_ROUND: begin
					res_sample_q <= rnd[SLOPE_FRAC +: SW];
					res_gain_q   <= gain_q;
					state_q      <= ST_DONE;
				end
				ST_DONE: begin
					if (out_free) begin
						out_sample_q <= res_sample_q;
						out_gain_q   <= res_gain_q;
						m_tvalid_q   <= 1'b1;
						state_q      <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	// The smoothed envelope can never rise above a full-scale level.
	a_env_bounded: assert property (@(posedge clk) disable iff (!arst_n)
		env_q <= ENV_FULL)
		else $error("envelope above full scale");

	// The divider remainder stays below the divisor throughout the division.
	a_div_rem: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_DIV) |-> (rem_q < env_q))
		else $error("divider remainder out of range");

	// A result never carries a gain above unity.
	a_gain_unity: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid_q |-> (out_gain_q <= GAIN_ONE))
		else $error("gain above unity");

	// Only one item is in work at a time.
	a_one_item: assert property (@(posedge clk) disable iff (!arst_n)
		in_acc |=> !s_tready)
		else $error("second item accepted while busy");

endmodule
